FILE: sv/ntc_pkg.sv
// Shared types, widths, breakpoint table and codes for the NTC code-to-temperature block.
// No dependencies; every other file of the block imports this package.

package ntc_pkg;

	localparam int POINT_COUNT = 14;
	localparam int TABLE_CAP   = 32;
	localparam int FRAC_BITS   = 8;
	localparam int LAST        = POINT_COUNT - 1;

	localparam int CODE_W   = 12;
	localparam int BASE_W   = 7;
	localparam int STEP_W   = 5;
	localparam int TEMP_W   = 18;
	localparam int STATUS_W = 2;

	localparam int SEG_W   = $clog2(POINT_COUNT);
	localparam int DIFF_W  = CODE_W;
	localparam int NUM_W   = DIFF_W + STEP_W + FRAC_BITS;
	localparam int RECIP_W = NUM_W + 1;
	localparam int QUO_W   = STEP_W + FRAC_BITS;
	localparam int DEG_W   = SEG_W + STEP_W + 2;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = (BASE_W > STEP_W) ? BASE_W : STEP_W;

	localparam logic [CFG_IDX_W-1:0] REG_BASE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_STEP = CFG_IDX_W'(1);

	localparam logic [STATUS_W-1:0] ST_INTERP = STATUS_W'(0);
	localparam logic [STATUS_W-1:0] ST_COLD   = STATUS_W'(1);
	localparam logic [STATUS_W-1:0] ST_HOT    = STATUS_W'(2);

	localparam logic signed [BASE_W-1:0] BASE_RESET = -BASE_W'(10);
	localparam logic [STEP_W-1:0]        STEP_RESET = STEP_W'(10);

	typedef logic [CODE_W-1:0]         code_t;
	typedef logic [DIFF_W-1:0]         diff_t;
	typedef logic [SEG_W-1:0]          seg_t;
	typedef logic [NUM_W-1:0]          num_t;
	typedef logic [QUO_W-1:0]          quo_t;
	typedef logic signed [BASE_W-1:0]  base_t;
	typedef logic [STEP_W-1:0]         step_t;
	typedef logic signed [TEMP_W-1:0]  temp_t;
	typedef logic [STATUS_W-1:0]       status_t;

	// descending breakpoints; entries past the built-in ones read as zero
	localparam code_t NTC_POINTS [TABLE_CAP] = '{
		0: CODE_W'(3950), 1: CODE_W'(3820), 2: CODE_W'(3640), 3: CODE_W'(3400),
		4: CODE_W'(3100), 5: CODE_W'(2760), 6: CODE_W'(2390), 7: CODE_W'(2020),
		8: CODE_W'(1680), 9: CODE_W'(1380), 10: CODE_W'(1120), 11: CODE_W'(900),
		12: CODE_W'(720), 13: CODE_W'(580), default: '0
	};

	// result of the segment search
	typedef struct packed {
		status_t status;
		seg_t    seg;
		logic    hit;
	} loc_t;

	// sideband carried alongside the divider
	typedef struct packed {
		status_t                  status;
		logic signed [DEG_W-1:0]  deg;
	} side_t;

	function automatic code_t point_at(input int i);
		code_t p;
		p = '0;
		if (i >= 0 && i < TABLE_CAP) begin
			p = NTC_POINTS[i];
		end
		return p;
	endfunction

endpackage

FILE: sv/ntc_adc_to_temperature.sv
// Top level of the NTC code-to-temperature converter: configuration registers,
// final quotient correction and output stage. Depends on ntc_pkg, ntc_locate,
// ntc_scale and ntc_divide.
//
// Usage:
//   Request: drive adc_code and raise start; it is taken at a rising edge with
//   start high and busy low. busy is always low, so a request may come every cycle.
//   Result: done is high for exactly one cycle with temperature_q8 (signed, 8
//   fraction bits, truncated) and range_status (interpolated, cold clamp, hot
//   clamp), one result per cycle.
//   The receiver cannot stall; every result is presented once and dropped after.
//   The pipeline has five register stages: segment search, numerator and
//   segment base, reciprocal multiply, quotient back-multiply, correction and sum.
//   Configuration: wr_en with wr_index 0 writes base_temperature, index 1 writes
//   temperature_step, from the low bits of wr_data. Write only while no request
//   is in flight.
//   Reset: clears the pipeline valid bits and sets base_temperature to -10 and
//   temperature_step to 10.

module ntc_adc_to_temperature (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  ntc_pkg::code_t                        adc_code,
	output logic                                  busy,
	input  logic                                  wr_en,
	input  logic [ntc_pkg::CFG_IDX_W-1:0]         wr_index,
	input  logic [ntc_pkg::CFG_DATA_W-1:0]        wr_data,
	output logic                                  done,
	output ntc_pkg::temp_t                        temperature_q8,
	output ntc_pkg::status_t                      range_status
);
	import ntc_pkg::*;

	localparam int SUM_W  = DEG_W + FRAC_BITS + 1;
	localparam int WIDE_W = (SUM_W > TEMP_W + 1) ? SUM_W : TEMP_W + 1;
	localparam logic signed [WIDE_W-1:0] OUT_MAX = WIDE_W'((longint'(1) << (TEMP_W - 1)) - 1);
	localparam logic signed [WIDE_W-1:0] OUT_MIN = -WIDE_W'(longint'(1) << (TEMP_W - 1));

	base_t base_q;
	step_t step_q;

	logic  accept;
	logic  valid_s1, valid_s2, valid_s4;
	loc_t  loc_s1;
	diff_t diff_s1;
	num_t  num_s2;
	seg_t  seg_s2;
	side_t side_s2, side_s4;
	num_t  num_s4, qd_s4, rem;
	quo_t  qest_s4, quo;
	diff_t den_s4;

	logic signed [WIDE_W-1:0] sum;
	temp_t                    temp_sat;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
			step_q <= STEP_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_BASE: base_q <= wr_data[BASE_W-1:0];
				REG_STEP: step_q <= wr_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	ntc_locate u_locate (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.adc_code (adc_code),
		.valid_s1 (valid_s1),
		.loc_s1   (loc_s1),
		.diff_s1  (diff_s1)
	);

	ntc_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.loc_s1   (loc_s1),
		.diff_s1  (diff_s1),
		.base     (base_q),
		.step     (step_q),
		.valid_s2 (valid_s2),
		.num_s2   (num_s2),
		.seg_s2   (seg_s2),
		.side_s2  (side_s2)
	);

	ntc_divide u_divide (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.num_s2   (num_s2),
		.seg_s2   (seg_s2),
		.side_s2  (side_s2),
		.valid_s4 (valid_s4),
		.num_s4   (num_s4),
		.qd_s4    (qd_s4),
		.qest_s4  (qest_s4),
		.den_s4   (den_s4),
		.side_s4  (side_s4)
	);

	// estimate is exact or one short; bump it when a full divisor remains
	assign rem = num_s4 - qd_s4;
	assign quo = (rem >= NUM_W'(den_s4)) ? qest_s4 + QUO_W'(1) : qest_s4;
	assign sum = (WIDE_W'($signed(side_s4.deg)) <<< FRAC_BITS) + WIDE_W'(quo);

	always_comb begin
		if (sum > OUT_MAX) begin
			temp_sat = OUT_MAX[TEMP_W-1:0];
		end else if (sum < OUT_MIN) begin
			temp_sat = OUT_MIN[TEMP_W-1:0];
		end else begin
			temp_sat = sum[TEMP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		temperature_q8 <= temp_sat;
		range_status   <= side_s4.status;
	end

`ifndef ASSERT_OFF
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##5 done)
		else $error("request did not produce a result after five cycles");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 5))
		else $error("result without a matching request");

	a_quo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> ({1'b0, rem} < ({1'b0, NUM_W'(den_s4)} << 1)))
		else $error("reciprocal quotient estimate off by more than one");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (range_status == ST_INTERP || range_status == ST_COLD
			|| range_status == ST_HOT))
		else $error("undefined range status on output");
`endif

endmodule

FILE: sv/ntc_locate.sv
// Stage 1: compares the ADC code against every breakpoint and picks clamp or segment.
// Depends on ntc_pkg.

module ntc_locate (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  ntc_pkg::code_t adc_code,
	output logic           valid_s1,
	output ntc_pkg::loc_t  loc_s1,
	output ntc_pkg::diff_t diff_s1
);
	import ntc_pkg::*;

	loc_t  loc;
	diff_t diff;

	always_comb begin
		loc.status = ST_INTERP;
		loc.seg    = '0;
		loc.hit    = 1'b0;
		diff       = '0;
		if (adc_code >= point_at(0)) begin
			loc.status = ST_COLD;
			loc.hit    = 1'b1;
		end else if (adc_code <= point_at(LAST)) begin
			loc.status = ST_HOT;
			loc.seg    = SEG_W'(LAST);
			loc.hit    = 1'b1;
		end else begin
			// walk downward so the lowest matching segment wins
			for (int i = LAST - 1; i >= 0; i--) begin
				if (adc_code <= point_at(i) && adc_code > point_at(i + 1)) begin
					loc.seg = SEG_W'(i);
					loc.hit = 1'b1;
					diff    = point_at(i) - adc_code;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		loc_s1  <= loc;
		diff_s1 <= diff;
	end

endmodule

FILE: sv/ntc_scale.sv
// Stage 2: forms the interpolation numerator and the segment start temperature.
// Depends on ntc_pkg.

module ntc_scale (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_s1,
	input  ntc_pkg::loc_t  loc_s1,
	input  ntc_pkg::diff_t diff_s1,
	input  ntc_pkg::base_t base,
	input  ntc_pkg::step_t step,
	output logic           valid_s2,
	output ntc_pkg::num_t  num_s2,
	output ntc_pkg::seg_t  seg_s2,
	output ntc_pkg::side_t side_s2
);
	import ntc_pkg::*;

	logic [DIFF_W+STEP_W-1:0] prod;
	logic [SEG_W+STEP_W-1:0]  ofs;
	logic signed [DEG_W-1:0]  deg;
	side_t                    side;

	assign prod = diff_s1 * step;
	assign ofs  = loc_s1.seg * step;
	assign deg  = DEG_W'(base) + DEG_W'(ofs);

	always_comb begin
		side.status = loc_s1.status;
		side.deg    = loc_s1.hit ? deg : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		num_s2  <= NUM_W'(prod) << FRAC_BITS;
		seg_s2  <= loc_s1.seg;
		side_s2 <= side;
	end

endmodule

FILE: sv/ntc_divide.sv
// Stages 3 and 4: divides the numerator by the segment width through a per-segment
// reciprocal; the quotient estimate is low by at most one. Depends on ntc_pkg.

module ntc_divide (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_s2,
	input  ntc_pkg::num_t  num_s2,
	input  ntc_pkg::seg_t  seg_s2,
	input  ntc_pkg::side_t side_s2,
	output logic           valid_s4,
	output ntc_pkg::num_t  num_s4,
	output ntc_pkg::num_t  qd_s4,
	output ntc_pkg::quo_t  qest_s4,
	output ntc_pkg::diff_t den_s4,
	output ntc_pkg::side_t side_s4
);
	import ntc_pkg::*;

	logic [RECIP_W-1:0]       recip_tab [POINT_COUNT];
	diff_t                    den_tab   [POINT_COUNT];
	logic [NUM_W+RECIP_W-1:0] prod;

	logic  valid_s3;
	num_t  num_s3;
	quo_t  qest_s3;
	diff_t den_s3;
	side_t side_s3;

	for (genvar g = 0; g < POINT_COUNT; g++) begin : g_seg
		localparam int     DEN      = int'(point_at(g)) - int'(point_at(g + 1));
		localparam int     DEN_SAFE = (DEN > 0) ? DEN : 1;
		localparam longint RECIP    = (longint'(1) << NUM_W) / DEN_SAFE;
		assign recip_tab[g] = RECIP_W'(RECIP);
		assign den_tab[g]   = DIFF_W'(DEN_SAFE);
	end

	assign prod = num_s2 * recip_tab[seg_s2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		qest_s3 <= prod[NUM_W +: QUO_W];
		num_s3  <= num_s2;
		den_s3  <= den_tab[seg_s2];
		side_s3 <= side_s2;

		qd_s4   <= NUM_W'(qest_s3 * den_s3);
		qest_s4 <= qest_s3;
		num_s4  <= num_s3;
		den_s4  <= den_s3;
		side_s4 <= side_s3;
	end

endmodule
